FILE: rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory polynomial evaluator package
// Shared widths, codes, state type and the fixed-point helper functions used
// by the evaluator datapath.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int AXES      = 3;
  localparam int COEF_W    = 64;
  localparam int TIME_W    = 32;
  localparam int TIME_FRAC = 24;
  localparam int TERM_W    = 3;
  localparam int FACT_W    = 6;
  localparam int TERMS_W   = 4;

  localparam logic [COEF_W-1:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [COEF_W-1:0] NEG_LIM = 64'h8000_0000_0000_0000;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_TERMS = 1'b0;
  localparam logic [TERMS_W-1:0] TERMS_RESET = 4'd8;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_POS   = 2'd1,
    FUNC_VEL   = 2'd2,
    FUNC_ACC   = 2'd3
  } func_t;

  // Sequencer states: one Horner step is MUL, SCALE, ADD.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ADD,
    ST_DONE
  } state_t;

  // A value together with its clamp flag.
  typedef struct packed {
    logic              sat;
    logic [COEF_W-1:0] val;
  } sat_val_t;

  // Derivative factor: 1, j or j*(j-1) for position, velocity, acceleration.
  function automatic logic [FACT_W-1:0] deriv_factor(input logic [TERM_W-1:0] j,
                                                     input logic [1:0] d);
    logic [FACT_W-1:0] jw;
    logic [FACT_W-1:0] jm;
    jw = FACT_W'(j);
    jm = FACT_W'(TERM_W'(j - 3'd1));
    case (d)
      2'd0:    deriv_factor = 6'd1;
      2'd1:    deriv_factor = jw;
      default: deriv_factor = FACT_W'(jw * jm);
    endcase
  endfunction

  // Coefficient times derivative factor, clamped to the signed 64-bit range.
  function automatic sat_val_t mul_factor(input logic [COEF_W-1:0] c,
                                          input logic [FACT_W-1:0] f);
    logic                     neg;
    logic [COEF_W-1:0]        mag;
    logic [COEF_W-1:0]        lim;
    logic [COEF_W+FACT_W-1:0] prod;
    sat_val_t                 res;
    neg  = c[COEF_W-1];
    mag  = neg ? (~c + 64'd1) : c;
    lim  = neg ? NEG_LIM : POS_LIM;
    prod = (COEF_W+FACT_W)'(mag) * (COEF_W+FACT_W)'(f);
    res.sat = 1'b0;
    if (prod > (COEF_W+FACT_W)'(lim)) begin
      res.sat = 1'b1;
      mag     = lim;
    end else begin
      mag = prod[COEF_W-1:0];
    end
    res.val = neg ? (~mag + 64'd1) : mag;
    return res;
  endfunction

  // Combine the two partial products of |acc| * t, round half up, drop the
  // time fraction and clamp with the original sign.
  function automatic sat_val_t scale_clamp(input logic [63:0] lo_pp,
                                           input logic [63:0] hi_pp,
                                           input logic neg);
    logic [96:0]       full;
    logic [72:0]       q;
    logic [COEF_W-1:0] lim;
    logic [COEF_W-1:0] mag;
    logic [96:0]       rnd;
    sat_val_t          res;
    rnd  = neg ? 97'((64'd1 << (TIME_FRAC - 1)) - 64'd1) : 97'(64'd1 << (TIME_FRAC - 1));
    full = 97'(lo_pp) + {1'b0, hi_pp, 32'd0} + rnd;
    q    = full[96:TIME_FRAC];
    lim  = neg ? NEG_LIM : POS_LIM;
    res.sat = 1'b0;
    if (q > 73'(lim)) begin
      res.sat = 1'b1;
      mag     = lim;
    end else begin
      mag = q[COEF_W-1:0];
    end
    res.val = neg ? (~mag + 64'd1) : mag;
    return res;
  endfunction

  // Saturating signed 64-bit add.
  function automatic sat_val_t add_sat(input logic [COEF_W-1:0] a,
                                       input logic [COEF_W-1:0] b);
    logic [COEF_W-1:0] s;
    sat_val_t          res;
    s = a + b;
    res.sat = 1'b0;
    res.val = s;
    if ((a[COEF_W-1] == b[COEF_W-1]) && (s[COEF_W-1] != a[COEF_W-1])) begin
      res.sat = 1'b1;
      res.val = a[COEF_W-1] ? NEG_LIM : POS_LIM;
    end
    return res;
  endfunction

endpackage

FILE: rtl/trajectory_polynomial_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Trajectory polynomial evaluator
// Coefficient table per segment and axis, Horner evaluation of position,
// velocity or acceleration for x, y and z in signed Q32.32.
// ----------------------------------------------------------------------------
// A write item stores one coefficient and produces no result; the block can
// take the next item straight after it. An evaluate item keeps the input
// stalled until its result has been loaded into the output register. The
// work is set by the Horner loop, run for n-d steps, where n is terms_in_use
// (capped at MAX_TERMS) and d is the derivative order (0, 1, 2). Each step
// runs one partial product phase (two 32x32 multiplies per axis), one
// round-and-clamp phase and one saturating add, and reads one coefficient row
// (all three axes) from the single coefficient memory port. The three axes
// run side by side. Results sit in an output register, so a stalled result
// does not block the next item from being accepted. Out-of-range segments or
// too few terms give a zero result without running the Horner loop.
module trajectory_polynomial_evaluator_unit #(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_TERMS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_segment,
  input  logic [1:0]         in_axis,
  input  logic [2:0]         in_term,
  input  logic signed [63:0] in_coefficient,
  input  logic [31:0]        in_time_value,
  // Result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value_x,
  output logic signed [63:0] out_value_y,
  output logic signed [63:0] out_value_z,
  output logic               out_saturated
);

  localparam int AXES = tpe_pkg::AXES;
  localparam int ROWS = MAX_SEGMENTS * MAX_TERMS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SEG_CMP_W = $clog2(MAX_SEGMENTS + 64) + 1;

  tpe_pkg::state_t state_r, state_nxt;

  logic [tpe_pkg::TERMS_W-1:0] terms_r;
  logic [tpe_pkg::TERMS_W-1:0] n_eff;

  logic [5:0]                  seg_r;
  logic [1:0]                  d_r;
  logic [tpe_pkg::TERM_W-1:0]  j_r;
  logic [31:0]                 t_r;
  logic                        sat_r;

  logic [63:0] acc_r   [AXES];
  logic [63:0] lo_pp_r [AXES];
  logic [63:0] hi_pp_r [AXES];
  logic        neg_r   [AXES];
  logic [63:0] mt_r    [AXES];
  logic [63:0] cf_r    [AXES];

  logic [AXES-1:0][63:0] coef_mem [ROWS];
  logic [AXES-1:0][63:0] rd_data_r;

  logic        out_valid_r;
  logic [63:0] out_val_r [AXES];
  logic        out_sat_r;

  logic              in_acc;
  logic              is_write;
  logic              seg_ok;
  logic              wr_ok;
  logic [1:0]        in_d;
  logic              eval_empty;
  logic [ROW_W-1:0]  wr_row;
  logic [ROW_W-1:0]  rd_row;
  logic              out_load;
  logic              cfg_wr;

  // Configuration register: terms per axis.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tpe_pkg::REG_TERMS) ? 32'(terms_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r <= tpe_pkg::TERMS_RESET;
    end else if (cfg_wr && (paddr[2] == tpe_pkg::REG_TERMS)) begin
      terms_r <= pwdata[tpe_pkg::TERMS_W-1:0];
    end
  end

  // Item decode.
  assign in_acc   = in_valid && !in_stall;
  assign is_write = (in_func == tpe_pkg::FUNC_WRITE);
  assign seg_ok   = SEG_CMP_W'(in_segment) < SEG_CMP_W'(MAX_SEGMENTS);
  assign wr_ok    = seg_ok && (int'(in_axis) < AXES) && (int'(in_term) < MAX_TERMS);
  assign in_d     = 2'(in_func - 2'(tpe_pkg::FUNC_POS));
  assign n_eff    = (terms_r > tpe_pkg::TERMS_W'(MAX_TERMS)) ?
                    tpe_pkg::TERMS_W'(MAX_TERMS) : terms_r;
  assign eval_empty = !seg_ok || (n_eff <= tpe_pkg::TERMS_W'(in_d));
  assign wr_row   = ROW_W'(int'(in_segment) * MAX_TERMS + int'(in_term));
  assign rd_row   = ROW_W'(int'(seg_r) * MAX_TERMS + int'(j_r));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state_r)
      tpe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !is_write) begin
          state_nxt = eval_empty ? tpe_pkg::ST_DONE : tpe_pkg::ST_MUL;
        end
      end
      tpe_pkg::ST_MUL:   state_nxt = tpe_pkg::ST_SCALE;
      tpe_pkg::ST_SCALE: state_nxt = tpe_pkg::ST_ADD;
      tpe_pkg::ST_ADD: begin
        state_nxt = (j_r == tpe_pkg::TERM_W'(d_r)) ? tpe_pkg::ST_DONE : tpe_pkg::ST_MUL;
      end
      tpe_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = tpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpe_pkg::ST_IDLE;
    endcase
  end

  // Coefficient memory: one row per segment and term, one lane per axis.
  // Writes happen only at item acceptance, reads only during evaluation.
  always_ff @(posedge clk) begin
    if (in_acc && is_write && wr_ok) begin
      coef_mem[wr_row][in_axis] <= in_coefficient;
    end
    if (state_r == tpe_pkg::ST_MUL) begin
      rd_data_r <= coef_mem[rd_row];
    end
  end

  // Per-axis arithmetic for the round-and-clamp and add phases.
  tpe_pkg::sat_val_t scl_res [AXES];
  tpe_pkg::sat_val_t fac_res [AXES];
  tpe_pkg::sat_val_t add_res [AXES];
  logic [63:0]       acc_mag [AXES];
  logic [tpe_pkg::FACT_W-1:0] factor;
  logic              scale_sat;
  logic              add_sat_any;

  assign factor = tpe_pkg::deriv_factor(j_r, d_r);

  always_comb begin
    scale_sat   = 1'b0;
    add_sat_any = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      acc_mag[a] = acc_r[a][63] ? (~acc_r[a] + 64'd1) : acc_r[a];
      scl_res[a] = tpe_pkg::scale_clamp(lo_pp_r[a], hi_pp_r[a], neg_r[a]);
      fac_res[a] = tpe_pkg::mul_factor(rd_data_r[a], factor);
      add_res[a] = tpe_pkg::add_sat(mt_r[a], cf_r[a]);
      scale_sat   = scale_sat | scl_res[a].sat | fac_res[a].sat;
      add_sat_any = add_sat_any | add_res[a].sat;
    end
  end

  // Horner datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      tpe_pkg::ST_IDLE: begin
        if (in_acc && !is_write) begin
          seg_r <= in_segment;
          d_r   <= in_d;
          t_r   <= in_time_value;
          j_r   <= tpe_pkg::TERM_W'(n_eff - 4'd1);
          sat_r <= 1'b0;
          for (int a = 0; a < AXES; a++) begin
            acc_r[a] <= 64'd0;
          end
        end
      end
      tpe_pkg::ST_MUL: begin
        for (int a = 0; a < AXES; a++) begin
          neg_r[a]   <= acc_r[a][63];
          lo_pp_r[a] <= 64'(acc_mag[a][31:0]) * 64'(t_r);
          hi_pp_r[a] <= 64'(acc_mag[a][63:32]) * 64'(t_r);
        end
      end
      tpe_pkg::ST_SCALE: begin
        sat_r <= sat_r | scale_sat;
        for (int a = 0; a < AXES; a++) begin
          mt_r[a] <= scl_res[a].val;
          cf_r[a] <= fac_res[a].val;
        end
      end
      tpe_pkg::ST_ADD: begin
        sat_r <= sat_r | add_sat_any;
        j_r   <= tpe_pkg::TERM_W'(j_r - 3'd1);
        for (int a = 0; a < AXES; a++) begin
          acc_r[a] <= add_res[a].val;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sat_r <= sat_r;
      for (int a = 0; a < AXES; a++) begin
        out_val_r[a] <= acc_r[a];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_x   = out_val_r[0];
  assign out_value_y   = out_val_r[1];
  assign out_value_z   = out_val_r[2];
  assign out_saturated = out_sat_r;

endmodule

FILE: rtl/tpe_checker.sv
// ----------------------------------------------------------------------------
// Trajectory polynomial evaluator checker
// Port-level assertions on item timing, bound to the top level.
// ----------------------------------------------------------------------------
module tpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] out_value_x
);

  // A waiting result is neither dropped nor is its x value changed.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_x))
    else $error("result dropped or changed while stalled");

  // An evaluate item keeps the block busy for at least the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func != tpe_pkg::FUNC_WRITE) |=> in_stall)
    else $error("evaluate item did not occupy the block");

  // A write item leaves the input side free in the cycle after it.
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == tpe_pkg::FUNC_WRITE) |=> !in_stall)
    else $error("write item held the input side");

  // A new result only appears at the end of an evaluation.
  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an evaluation in progress");

endmodule

bind trajectory_polynomial_evaluator_unit tpe_checker u_tpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_value_x (out_value_x)
);
